// File: design/bdpd_pkg.sv
package bdpd_pkg;

  // Geometry of the block
  localparam int unsigned REF_BITS      = 32;
  localparam int unsigned DUMP_POS_BITS = 16;

  localparam int unsigned IDX_W   = $clog2(REF_BITS);
  localparam int unsigned CNT_W   = $clog2(REF_BITS + 1);
  localparam int unsigned ARITH_W = ((DUMP_POS_BITS > CNT_W) ? DUMP_POS_BITS : CNT_W) + 1;

  // Register and field widths
  localparam int unsigned REF_BITS_W   = 32;
  localparam int unsigned REF_LEN_W    = 6;
  localparam int unsigned MIN_RUN_W    = 6;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned REF_START_W  = 5;
  localparam int unsigned RUN_LEN_W    = 6;
  localparam int unsigned IN_DATA_W    = 8;
  localparam int unsigned OUT_FIELDS_W = REF_START_W + DUMP_POS_BITS + RUN_LEN_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [REF_LEN_W-1:0] REF_LENGTH_RST = REF_LEN_W'(32);
  localparam logic [MIN_RUN_W-1:0] MIN_RUN_RST    = MIN_RUN_W'(8);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REF_BITS   = 2'd0,
    CFG_REF_LENGTH = 2'd1,
    CFG_MIN_RUN    = 2'd2
  } cfg_reg_e;

  // Per-bit control broadcast to every cell
  typedef struct packed {
    logic                     step;
    logic                     dump_bit;
    logic                     last;
    logic [CNT_W-1:0]         len_use;
    logic [MIN_RUN_W-1:0]     thr;
    logic [DUMP_POS_BITS-1:0] dump_pos;
  } bdpd_ctrl_t;

  // Run finished in one cell on the current bit
  typedef struct packed {
    logic                     valid;
    logic [IDX_W-1:0]         ref_start;
    logic [DUMP_POS_BITS-1:0] dump_start;
    logic [CNT_W-1:0]         run_length;
    logic                     dzero;
  } bdpd_res_t;

  // Next result offered by the sorter
  typedef struct packed {
    logic                     valid;
    logic [IDX_W-1:0]         ref_start;
    logic [DUMP_POS_BITS-1:0] dump_start;
    logic [CNT_W-1:0]         run_length;
    logic                     last;
  } bdpd_head_t;

  function automatic logic [IDX_W-1:0] lowest_set(logic [REF_BITS-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = REF_BITS - 1; i >= 0; i--) begin
      if (v[i]) idx = IDX_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [IDX_W-1:0] highest_set(logic [REF_BITS-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < REF_BITS; i++) begin
      if (v[i]) idx = IDX_W'(i);
    end
    return idx;
  endfunction

endpackage

// File: design/bit_dot_plot_diagonal_runs.sv
// Diagonal match runs between a configured reference bit string and a
// streamed dump bit string.
//
// Configuration: write ref_bits (index 0), ref_length (1) and min_run (2)
// on the cfg channel while the block is idle; cfg_ready_o is always high.
// Input: one dump bit per item on s_axis, tlast on the final bit of a string.
// Output: one item per maximal diagonal run of at least min_run equal bits,
// tlast on the last run caused by a given dump bit. Runs of one dump bit
// come out by ascending reference start, then ascending dump start.
//
// Throughput: one dump bit per cycle while bits close no runs. A bit that
// closes runs holds them in the sorter, which releases one per cycle while
// the output register can advance; the next bit is taken in the cycle its
// last run moves to the output register. Runs are registered in the sorter
// when their bit is accepted, then in the output register. A stalled receiver
// freezes the output register and the sorter, and with them the input side.
// Reset: cells and dump position clear, registers take ref_bits 0,
// ref_length 32, min_run 8.
module bit_dot_plot_diagonal_runs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bdpd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bdpd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Dump bit stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [bdpd_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // [0] dump_bit
  input  logic                                s_axis_tlast,
  // Run stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // ref_start, dump_start, run_length from the lowest bit up
  output logic [bdpd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tlast   // last_of_run
);
  import bdpd_pkg::*;

  logic [REF_BITS_W-1:0]    ref_bits_q;
  logic [REF_LEN_W-1:0]     ref_length_q;
  logic [MIN_RUN_W-1:0]     min_run_q;
  logic [DUMP_POS_BITS-1:0] dump_pos_q, dump_pos_d;

  logic                     in_fire, pop;
  logic [REF_BITS-1:0]      ref_vec;
  logic [CNT_W-1:0]         len_use;
  bdpd_ctrl_t               ctrl;
  bdpd_head_t               head;

  logic [REF_BITS-1:0][CNT_W-1:0] cnt;
  bdpd_res_t [REF_BITS-1:0]       res;

  logic                           out_valid_q, out_valid_d;
  logic [REF_START_W-1:0]         out_rs_q;
  logic [DUMP_POS_BITS-1:0]       out_ds_q;
  logic [RUN_LEN_W-1:0]           out_len_q;
  logic                           out_last_q;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_bits_q   <= '0;
      ref_length_q <= REF_LENGTH_RST;
      min_run_q    <= MIN_RUN_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_REF_BITS:   ref_bits_q   <= cfg_data_i;
        CFG_REF_LENGTH: ref_length_q <= REF_LEN_W'(cfg_data_i);
        CFG_MIN_RUN:    min_run_q    <= MIN_RUN_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Clamp the reference length to 1..REF_BITS and the threshold to at least 1
  always_comb begin
    if (ref_length_q == '0) begin
      len_use = CNT_W'(1);
    end else if (32'(ref_length_q) > REF_BITS) begin
      len_use = CNT_W'(REF_BITS);
    end else begin
      len_use = CNT_W'(ref_length_q);
    end
  end

  assign ref_vec = REF_BITS'(ref_bits_q);

  // Input side: take a bit when the sorter is empty or hands off its last run
  assign s_axis_tready = !head.valid || (pop && head.last);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign ctrl.step     = in_fire;
  assign ctrl.dump_bit = s_axis_tdata[0];
  assign ctrl.last     = s_axis_tlast;
  assign ctrl.len_use  = len_use;
  assign ctrl.thr      = (min_run_q == '0) ? MIN_RUN_W'(1) : min_run_q;
  assign ctrl.dump_pos = dump_pos_q;

  // Dump position: saturate at the top, restart after the final bit
  always_comb begin
    dump_pos_d = dump_pos_q;
    if (in_fire) begin
      if (s_axis_tlast) begin
        dump_pos_d = '0;
      end else if (dump_pos_q != '1) begin
        dump_pos_d = dump_pos_q + DUMP_POS_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dump_pos_q <= '0;
    end else begin
      dump_pos_q <= dump_pos_d;
    end
  end

  // Cell chain: each cell keeps the run length of one diagonal and passes it on
  for (genvar g = 0; g < REF_BITS; g++) begin : g_cell
    logic [CNT_W-1:0] prev_cnt;
    if (g == 0) begin : g_first
      assign prev_cnt = '0;
    end else begin : g_rest
      assign prev_cnt = cnt[g-1];
    end

    bdpd_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(g)),
      .ref_bit_i  (ref_vec[g]),
      .prev_cnt_i (prev_cnt),
      .ctrl_i     (ctrl),
      .cnt_o      (cnt[g]),
      .res_o      (res[g])
    );
  end

  // Sorter holds the runs of one bit and releases them in order
  bdpd_sorter u_sorter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (in_fire),
    .res_i  (res),
    .pop_i  (pop),
    .head_o (head)
  );

  // Output register: advance when empty or when the receiver takes the item
  assign pop = head.valid && (!out_valid_q || m_axis_tready);

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_rs_q   <= REF_START_W'(head.ref_start);
      out_ds_q   <= head.dump_start;
      out_len_q  <= RUN_LEN_W'(head.run_length);
      out_last_q <= head.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'({out_len_q, out_ds_q, out_rs_q});
  assign m_axis_tlast  = out_last_q;

  // A new bit enters a non-empty sorter only while it hands off its final run
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && head.valid |-> pop && head.last)
    else $error("bit accepted while sorter still holds runs");

  // Handing off the final run with no new bit leaves the sorter empty
  a_sorter_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && head.last && !in_fire |=> !head.valid)
    else $error("sorter not empty after its final run");

  // The final bit of a string restarts the dump position
  a_pos_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && s_axis_tlast |=> dump_pos_q == '0)
    else $error("dump position not cleared after final bit");

endmodule

// File: design/bdpd_cell.sv
module bdpd_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [bdpd_pkg::IDX_W-1:0]     cell_idx_i,
  input  logic                           ref_bit_i,
  input  logic [bdpd_pkg::CNT_W-1:0]     prev_cnt_i,
  input  bdpd_pkg::bdpd_ctrl_t           ctrl_i,
  output logic [bdpd_pkg::CNT_W-1:0]     cnt_o,
  output bdpd_pkg::bdpd_res_t            res_o
);
  import bdpd_pkg::*;

  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [CNT_W-1:0]         inc;
  logic [CNT_W-1:0]         run_len;
  logic                     match, active, at_end, rep_a, rep_b;
  logic [DUMP_POS_BITS-1:0] y_prev, y_end;
  logic [IDX_W:0]           x_end;
  logic [ARITH_W-1:0]       end_plus;

  assign match  = (ref_bit_i == ctrl_i.dump_bit);
  assign active = 32'(cell_idx_i) < 32'(ctrl_i.len_use);
  assign at_end = (32'(cell_idx_i) + 32'd1) == 32'(ctrl_i.len_use);
  assign inc    = prev_cnt_i + CNT_W'(1);

  // Run on this diagonal closes here at the reference end or on the final bit
  assign rep_a = active && match && (at_end || ctrl_i.last) && (32'(inc) >= 32'(ctrl_i.thr));
  // Mismatch closes the run that reached the previous cell on the previous bit
  assign rep_b = active && !match && (32'(prev_cnt_i) >= 32'(ctrl_i.thr));

  always_comb begin
    y_prev   = (ctrl_i.dump_pos == '0) ? '0 : ctrl_i.dump_pos - DUMP_POS_BITS'(1);
    run_len  = match ? inc : prev_cnt_i;
    y_end    = match ? ctrl_i.dump_pos : y_prev;
    x_end    = match ? (IDX_W+1)'(cell_idx_i) + (IDX_W+1)'(1) : (IDX_W+1)'(cell_idx_i);
    end_plus = ARITH_W'(y_end) + ARITH_W'(1);

    res_o.valid      = rep_a || rep_b;
    res_o.run_length = run_len;
    res_o.ref_start  = IDX_W'(x_end - (IDX_W+1)'(run_len));
    // Start position floors at zero
    if (end_plus >= ARITH_W'(run_len)) begin
      res_o.dump_start = DUMP_POS_BITS'(end_plus - ARITH_W'(run_len));
    end else begin
      res_o.dump_start = '0;
    end
    res_o.dzero = (res_o.dump_start == '0);
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl_i.step) begin
      cnt_d = (active && match && !ctrl_i.last) ? inc : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign cnt_o = cnt_q;

endmodule

// File: design/bdpd_sorter.sv
module bdpd_sorter (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      load_i,
  input  bdpd_pkg::bdpd_res_t [bdpd_pkg::REF_BITS-1:0] res_i,
  input  logic                                      pop_i,
  output bdpd_pkg::bdpd_head_t                      head_o
);
  import bdpd_pkg::*;

  // hit_q[r][x]: cell x holds a result that starts at reference position r
  logic [REF_BITS-1:0][REF_BITS-1:0]      hit_q, hit_d;
  logic [REF_BITS-1:0][CNT_W-1:0]         len_q;
  logic [REF_BITS-1:0][DUMP_POS_BITS-1:0] ds_q;
  logic [REF_BITS-1:0]                    dz_q;

  logic [REF_BITS-1:0] row_any, row, zmask, r_hot, x_hot;
  logic [IDX_W-1:0]    r_sel, x_sel;

  always_comb begin
    for (int r = 0; r < REF_BITS; r++) begin
      row_any[r] = |hit_q[r];
    end
    r_sel = lowest_set(row_any);
    row   = hit_q[r_sel];
    zmask = row & dz_q;
    // Equal start: zero dump starts first by cell, then larger cells have earlier starts
    x_sel = (|zmask) ? lowest_set(zmask) : highest_set(row);
    r_hot = REF_BITS'(1) << r_sel;
    x_hot = REF_BITS'(1) << x_sel;

    head_o.valid      = |row_any;
    head_o.ref_start  = r_sel;
    head_o.dump_start = ds_q[x_sel];
    head_o.run_length = len_q[x_sel];
    head_o.last       = !(|(row_any & ~r_hot)) && !(|(row & ~x_hot));
  end

  always_comb begin
    hit_d = hit_q;
    if (load_i) begin
      for (int r = 0; r < REF_BITS; r++) begin
        for (int x = 0; x < REF_BITS; x++) begin
          hit_d[r][x] = res_i[x].valid && (res_i[x].ref_start == IDX_W'(r));
        end
      end
    end else if (pop_i) begin
      hit_d[r_sel][x_sel] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= '0;
    end else begin
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int x = 0; x < REF_BITS; x++) begin
        len_q[x] <= res_i[x].run_length;
        ds_q[x]  <= res_i[x].dump_start;
        dz_q[x]  <= res_i[x].dzero;
      end
    end
  end

endmodule

// File: test/tb_bit_dot_plot_diagonal_runs.sv
`timescale 1ns / 1ps

module tb_bit_dot_plot_diagonal_runs;
  import bdpd_pkg::*;

  localparam int PHASES       = 7;
  localparam int PHASE_ITEMS  = 12;
  localparam int SETTLE_LAT   = 4;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 3000;
  localparam int MID_BITS     = 8;
  localparam int DIR_ROWS     = 22;

  // One run as it leaves the block
  typedef struct packed {
    logic [REF_START_W-1:0]   rs;
    logic [DUMP_POS_BITS-1:0] ds;
    logic [RUN_LEN_W-1:0]     len;
    logic                     lst;
  } run_item_t;

  typedef enum logic {ROW_CFG, ROW_BIT} row_kind_e;

  // Directed row: a register write, or a dump bit with an optional typed-in run
  typedef struct packed {
    row_kind_e                kind;
    cfg_reg_e                 reg_idx;
    logic [CFG_DATA_W-1:0]    value;
    logic                     dbit;
    logic                     lst;
    logic                     typed;
    logic [REF_START_W-1:0]   rs;
    logic [DUMP_POS_BITS-1:0] ds;
    logic [RUN_LEN_W-1:0]     len;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  cfg_reg_e              cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  // Mirror of the block: registers, diagonal cells, dump position
  logic [REF_BITS_W-1:0]    ref_pattern = '0;
  logic [REF_LEN_W-1:0]     ref_len_reg = REF_LENGTH_RST;
  logic [MIN_RUN_W-1:0]     min_run_reg = MIN_RUN_RST;
  logic [RUN_LEN_W-1:0]     diag_cnt [REF_BITS];
  logic [DUMP_POS_BITS-1:0] dump_pos = '0;

  run_item_t pending_runs [$];
  run_item_t got_run;
  run_item_t want_run;

  int  errors       = 0;
  int  bits_sent    = 0;
  int  strings_sent = 0;
  int  runs_checked = 0;
  int  reg_writes   = 0;
  int  longest_run  = 0;
  int  quiet_cycles = 0;
  bit  tx_idle_on   = 1'b1;
  bit  rx_idle_on   = 1'b1;
  bit  hold_req     = 1'b0;
  int  hold_left    = 0;
  int  rx_gap       = 0;
  int  rx_tick      = 0;

  // Directed rows, walked in order; typed rows carry the single run they cause
  dir_row_t dir_tab [DIR_ROWS] = '{
    // out of reset: ref all zero, a one matches nothing, a zero gives runs of 1 below min_run 8
    '{ROW_BIT, CFG_REF_BITS,   32'h0,         1'b1, 1'b1, 1'b0, 5'd0, 16'd0, 6'd0},
    '{ROW_BIT, CFG_REF_BITS,   32'h0,         1'b0, 1'b1, 1'b0, 5'd0, 16'd0, 6'd0},
    // single reference bit, every match reports a run of one
    '{ROW_CFG, CFG_REF_BITS,   32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 5'd0, 16'd0, 6'd0},
    '{ROW_CFG, CFG_REF_LENGTH, 32'd1,         1'b0, 1'b0, 1'b0, 5'd0, 16'd0, 6'd0},
    '{ROW_CFG, CFG_MIN_RUN,    32'd1,         1'b0, 1'b0, 1'b0, 5'd0, 16'd0, 6'd0},
    '{ROW_BIT, CFG_REF_BITS,   32'h0,         1'b1, 1'b0, 1'b1, 5'd0, 16'd0, 6'd1},
    '{ROW_BIT, CFG_REF_BITS,   32'h0,         1'b0, 1'b0, 1'b0, 5'd0, 16'd0, 6'd0},
    '{ROW_BIT, CFG_REF_BITS,   32'h0,         1'b1, 1'b1, 1'b1, 5'd0, 16'd2, 6'd1},
    // zero length acts as one
    '{ROW_CFG, CFG_REF_LENGTH, 32'd0,         1'b0, 1'b0, 1'b0, 5'd0, 16'd0, 6'd0},
    '{ROW_BIT, CFG_REF_BITS,   32'h0,         1'b1, 1'b1, 1'b1, 5'd0, 16'd0, 6'd1},
    // oversized length clamps to full width, zero threshold acts as one:
    // one bit marked last closes a run in every cell
    '{ROW_CFG, CFG_REF_BITS,   32'h0,         1'b0, 1'b0, 1'b0, 5'd0, 16'd0, 6'd0},
    '{ROW_CFG, CFG_REF_LENGTH, 32'd63,        1'b0, 1'b0, 1'b0, 5'd0, 16'd0, 6'd0},
    '{ROW_CFG, CFG_MIN_RUN,    32'd0,         1'b0, 1'b0, 1'b0, 5'd0, 16'd0, 6'd0},
    '{ROW_BIT, CFG_REF_BITS,   32'h0,         1'b0, 1'b1, 1'b0, 5'd0, 16'd0, 6'd0},
    // runs closed at the reference end, then by a mismatch
    '{ROW_CFG, CFG_REF_LENGTH, 32'd4,         1'b0, 1'b0, 1'b0, 5'd0, 16'd0, 6'd0},
    '{ROW_CFG, CFG_MIN_RUN,    32'd2,         1'b0, 1'b0, 1'b0, 5'd0, 16'd0, 6'd0},
    '{ROW_BIT, CFG_REF_BITS,   32'h0,         1'b0, 1'b0, 1'b0, 5'd0, 16'd0, 6'd0},
    '{ROW_BIT, CFG_REF_BITS,   32'h0,         1'b0, 1'b0, 1'b1, 5'd2, 16'd0, 6'd2},
    '{ROW_BIT, CFG_REF_BITS,   32'h0,         1'b1, 1'b1, 1'b0, 5'd0, 16'd0, 6'd0},
    // threshold beyond any possible run: silence
    '{ROW_CFG, CFG_MIN_RUN,    32'd33,        1'b0, 1'b0, 1'b0, 5'd0, 16'd0, 6'd0},
    '{ROW_BIT, CFG_REF_BITS,   32'h0,         1'b0, 1'b0, 1'b0, 5'd0, 16'd0, 6'd0},
    '{ROW_BIT, CFG_REF_BITS,   32'h0,         1'b0, 1'b1, 1'b0, 5'd0, 16'd0, 6'd0}
  };

  bit_dot_plot_diagonal_runs uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  // Gap length: three bands, the shortest most often, now and then a long pause
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  function automatic run_item_t make_run(int x_end, int y_end, int n);
    run_item_t r;
    r.rs  = REF_START_W'(x_end + 1 - n);
    r.ds  = (y_end + 1 >= n) ? DUMP_POS_BITS'(y_end + 1 - n) : '0;
    r.len = RUN_LEN_W'(n);
    r.lst = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  // Advance the mirror by one dump bit; queue the runs it closes when asked
  task automatic predict_runs(input logic d, input logic lst, input bit queue_them);
    int len_use;
    int thr;
    int y;
    int yprev;
    int prev;
    int c;
    int k;
    logic [RUN_LEN_W-1:0] nc [REF_BITS];
    run_item_t found [$];
    run_item_t r;
    len_use = (ref_len_reg == 0) ? 1 : int'(ref_len_reg);
    if (len_use > REF_BITS) len_use = REF_BITS;
    thr   = (min_run_reg == 0) ? 1 : int'(min_run_reg);
    y     = int'(dump_pos);
    yprev = (y == 0) ? 0 : y - 1;
    for (int x = 0; x < REF_BITS; x++) nc[x] = '0;
    for (int x = 0; x < len_use; x++) begin
      prev = (x == 0) ? 0 : int'(diag_cnt[x-1]);
      if (ref_pattern[x] == d) begin
        c     = prev + 1;
        nc[x] = RUN_LEN_W'(c);
        // a run also ends at the last reference bit in use or the last dump bit
        if ((x + 1 == len_use || lst) && c >= thr) found.insert(found.size(), make_run(x, y, c));
      end else if (x > 0 && prev >= thr) begin
        // mismatch closes the run that ended one step back on this diagonal
        found.insert(found.size(), make_run(x - 1, yprev, prev));
      end
    end
    // order by reference start, then dump start
    for (int i = 1; i < found.size(); i++) begin
      r = found[i];
      k = i - 1;
      while (k >= 0 && {found[k].rs, found[k].ds} > {r.rs, r.ds}) begin
        found[k+1] = found[k];
        k--;
      end
      found[k+1] = r;
    end
    if (queue_them) begin
      for (int i = 0; i < found.size(); i++) begin
        r     = found[i];
        r.lst = (i == found.size() - 1);
        pending_runs.insert(pending_runs.size(), r);
      end
    end
    if (lst) begin
      for (int x = 0; x < REF_BITS; x++) diag_cnt[x] = '0;
      dump_pos = '0;
    end else begin
      for (int x = 0; x < REF_BITS; x++) diag_cnt[x] = nc[x];
      if (dump_pos != '1) dump_pos = dump_pos + 1'b1;
    end
  endtask

  // Offer one dump bit after a gap, hold it until taken, then predict
  task automatic send_bit(input logic d, input logic lst, input int gap, input bit queue_them);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'(d);
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_runs(d, lst, queue_them);
    bits_sent++;
  endtask

  function automatic int tx_gap();
    if (!tx_idle_on || $urandom_range(0, 1) == 0) return 0;
    return pick_gap();
  endfunction

  // Drop the input, wait out every pending run and the block's pipeline
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_LAT) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_REF_BITS:   ref_pattern = val;
      CFG_REF_LENGTH: ref_len_reg = val[REF_LEN_W-1:0];
      CFG_MIN_RUN:    min_run_reg = val[MIN_RUN_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One dump string, last bit marked: either a copy of the reference from
  // some offset with occasional flipped bits, or plain noise
  task automatic send_string(input bit copy, input int off, input int slen, input int flip_pct);
    logic d;
    for (int k = 0; k < slen; k++) begin
      if (copy) d = ref_pattern[(off + k) % REF_BITS] ^ ($urandom_range(0, 99) < flip_pct);
      else d = 1'($urandom_range(0, 1));
      send_bit(d, k == slen - 1, tx_gap(), 1'b1);
    end
    strings_sent++;
  endtask

  // Receiver: random ready with idle stretches, plus a long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (rx_gap > 0) begin
        m_axis_tready <= 1'b0;
        rx_gap--;
      end else begin
        m_axis_tready <= 1'b1;
        if (rx_idle_on && $urandom_range(0, 7) == 0) rx_gap = pick_gap();
      end
      rx_tick++;
      if (rx_tick % 256 == 0) rx_idle_on = ($urandom_range(0, 3) != 0);
    end
  end

  // Check every run taken against the oldest one expected
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_run.rs  = m_axis_tdata[REF_START_W-1:0];
      got_run.ds  = m_axis_tdata[REF_START_W +: DUMP_POS_BITS];
      got_run.len = m_axis_tdata[REF_START_W + DUMP_POS_BITS +: RUN_LEN_W];
      got_run.lst = m_axis_tlast;
      if (int'(got_run.len) > longest_run) longest_run = int'(got_run.len);
      if (pending_runs.size() == 0) begin
        report_mismatch($sformatf("unexpected run ref_start=%0d dump_start=%0d len=%0d",
                                  got_run.rs, got_run.ds, got_run.len));
      end else begin
        want_run = pending_runs.pop_front();
        if (got_run.rs !== want_run.rs)
          report_mismatch($sformatf("ref_start %0d, expected %0d", got_run.rs, want_run.rs));
        if (got_run.ds !== want_run.ds)
          report_mismatch($sformatf("dump_start %0d, expected %0d", got_run.ds, want_run.ds));
        if (got_run.len !== want_run.len)
          report_mismatch($sformatf("run_length %0d, expected %0d", got_run.len, want_run.len));
        if (got_run.lst !== want_run.lst)
          report_mismatch($sformatf("tlast %0b, expected %0b", got_run.lst, want_run.lst));
      end
      runs_checked++;
    end
  end

  // Watchdog: end the run when no channel moves an item for too long
  always @(posedge clk_i) begin
    if ((cfg_valid_i && cfg_ready_o) || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int ph_len [PHASES];
    int ph_min [PHASES];
    logic [CFG_DATA_W-1:0] pat;
    int items;
    int slen;
    ph_len = '{32, 5, 1, 32, 63, 17, 12};
    ph_min = '{8, 2, 1, 32, 0, 33, 4};
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_REF_BITS;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    for (int x = 0; x < REF_BITS; x++) diag_cnt[x] = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: extremes of the registers and the ways a run can end
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        settle();
        write_reg(dir_tab[i].reg_idx, dir_tab[i].value);
      end else begin
        send_bit(dir_tab[i].dbit, dir_tab[i].lst, tx_gap(), !dir_tab[i].typed);
        if (dir_tab[i].typed)
          pending_runs.insert(pending_runs.size(),
                              '{dir_tab[i].rs, dir_tab[i].ds, dir_tab[i].len, 1'b1});
      end
    end

    // Random part: one register setting per phase, mostly copied strings
    for (int p = 0; p < PHASES; p++) begin
      settle();
      pat = $urandom();
      if (p <= 1) pat = '1;
      if (p == 2) pat = '0;
      write_reg(CFG_REF_BITS, pat);
      // upper data bits are junk the register must drop
      write_reg(CFG_REF_LENGTH, ($urandom() << REF_LEN_W) | CFG_DATA_W'(ph_len[p]));
      write_reg(CFG_MIN_RUN, ($urandom() << MIN_RUN_W) | CFG_DATA_W'(ph_min[p]));
      // first phase: sender never pauses while the receiver holds off,
      // so results back up and the input stalls
      tx_idle_on = (p != 0);
      if (p == 0) hold_req = 1'b1;
      items = 0;
      // all-ones string on an all-ones reference: a run closes on every
      // bit from the eighth on, enough to fill the block during the hold
      if (p == 0) begin
        send_string(1'b1, 0, 12, 0);
        items += 12;
      end
      // full-width threshold: force one exact copy so a run spans all 32 bits
      if (p == 3) begin
        send_string(1'b1, 0, REF_BITS, 0);
        items += REF_BITS;
      end
      while (items < PHASE_ITEMS) begin
        slen = $urandom_range(1, 24);
        if ($urandom_range(0, 99) < 80)
          send_string(1'b1, $urandom_range(0, REF_BITS - 1), slen, 8);
        else
          send_string(1'b0, 0, slen, 0);
        items += slen;
      end
    end

    // Mid-string threshold change: a stretch with reporting shut off,
    // then a lower threshold and the rest of the string as a copy
    settle();
    write_reg(CFG_REF_BITS, $urandom());
    write_reg(CFG_REF_LENGTH, CFG_DATA_W'(REF_BITS));
    write_reg(CFG_MIN_RUN, CFG_DATA_W'(63));
    for (int i = 0; i < MID_BITS; i++) send_bit(1'($urandom_range(0, 1)), 1'b0, 0, 1'b1);
    settle();
    write_reg(CFG_MIN_RUN, CFG_DATA_W'(3));
    tx_idle_on = 1'b1;
    send_string(1'b1, 0, 12, 0);

    settle();
    $display("Checked %0d runs from %0d dump bits in %0d strings, %0d register writes.",
             runs_checked, bits_sent, strings_sent, reg_writes);
    $display("Longest run %0d; length and threshold swept to both ends, threshold moved mid-string.",
             longest_run);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
